>>> hdl/icdf_pkg.sv
// Shared types and constants for the inverse-CDF table sampler.
`default_nettype none

package icdf_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int FRAC_BITS       = 16;

    localparam int VAL_W    = 17;
    localparam int KEY_W    = 16;
    localparam int IDX_W    = 7;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 2;

    localparam int DIFF_W = VAL_W + 1;   // signed difference of two table values
    localparam int PROD_W = 2 * VAL_W;   // |dp| * |dk|
    localparam int QUO_W  = VAL_W + 1;   // quotient bits kept before saturation
    localparam int RES_W  = QUO_W + 2;   // signed p[s] + q
    localparam int STEP_W = $clog2(QUO_W + 1);

    localparam logic [CNT_W-1:0] ENTRIES_RST = CNT_W'(128);
    localparam logic [VAL_W-1:0] ONE_VAL     = VAL_W'(1) << FRAC_BITS;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL  = 2'd0,
        ST_CLAMPED = 2'd1,
        ST_FLAT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0] cdf;
        logic [VAL_W-1:0] point;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [VAL_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             overflow;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/icdf_table.sv
// Table memory: cdf and point per entry, one write port, one registered read port.
`default_nettype none

module icdf_table #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  icdf_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output icdf_pkg::entry_t rd_data
);
    import icdf_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/icdf_divider.sv
// Iterative unsigned divider, one quotient bit per cycle, with early overflow detect.
`default_nettype none

module icdf_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  icdf_pkg::div_req_t req,
    output icdf_pkg::div_rsp_t rsp
);
    import icdf_pkg::*;

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] den_sh_reg, den_sh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic              ovf_now;

    // quotient would need more than QUO_W bits: result saturates anyway
    assign ovf_now = {1'b0, req.num} >= {req.den, QUO_W'(0)};

    always_comb
    begin
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        ovf_next    = ovf_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            rem_next    = req.num;
            den_sh_next = {req.den, (QUO_W-1)'(0)};
            quo_next    = '0;
            step_next   = STEP_W'(QUO_W);
            ovf_next    = ovf_now;
            busy_next   = !ovf_now;
            done_next   = ovf_now;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= den_sh_reg)
            begin
                rem_next = rem_reg - den_sh_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            den_sh_next = den_sh_reg >> 1;
            step_next   = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        quo_reg    <= quo_next;
    end

    assign rsp = '{done: done_reg, overflow: ovf_reg, quo: quo_reg};

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

>>> hdl/inverse_cdf_table_sampler_core.sv
// Query: a binary search of P probes (P <= ceil(log2 n)), then interpolation through the divider, to out_valid.
// Flat segment or clamp past the last entry skips the multiply and divide; divider overflow ends early, saturated.
// Load: written on accept, no result. One item in flight at a time;
// a new item is taken while the result waits.
// Search rate is one probe per cycle off the table's single read port; the 18-step divider dominates.
// Reset: control cleared, entries_in_use = 128; table contents undefined until loaded.
`default_nettype none

module inverse_cdf_table_sampler_core #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [icdf_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [icdf_pkg::IDX_W-1:0]    entry_index,
    input  logic [icdf_pkg::VAL_W-1:0]    cdf_value,
    input  logic [icdf_pkg::VAL_W-1:0]    point_value,
    input  logic [icdf_pkg::KEY_W-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [icdf_pkg::VAL_W-1:0]    sample,
    output logic [icdf_pkg::STATUS_W-1:0] status
);
    import icdf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_SEARCH   = 8'b00000010,
        S_RD_E     = 8'b00000100,
        S_DIFF     = 8'b00001000,
        S_MUL      = 8'b00010000,
        S_DIV_GO   = 8'b00100000,
        S_DIV_WAIT = 8'b01000000,
        S_FINISH   = 8'b10000000
    } state_t;

    function automatic logic [VAL_W-1:0] mag(input logic [DIFF_W-1:0] x);
        logic [DIFF_W-1:0] neg_x;
        neg_x = -x;
        return x[DIFF_W-1] ? neg_x[VAL_W-1:0] : x[VAL_W-1:0];
    endfunction

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  entries_in_use_reg, entries_in_use_next;
    logic              out_valid_reg, out_valid_next;
    // payload
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     start_reg, start_next;
    logic [CW-1:0]     end_reg, end_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  cs_reg, cs_next;
    logic [VAL_W-1:0]  ps_reg, ps_next;
    logic [VAL_W-1:0]  dp_mag_reg, dp_mag_next;
    logic [VAL_W-1:0]  dk_mag_reg, dk_mag_next;
    logic [VAL_W-1:0]  dc_mag_reg, dc_mag_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]  res_sample_reg, res_sample_next;
    status_t           res_status_reg, res_status_next;
    logic [VAL_W-1:0]  sample_reg, sample_next;
    status_t           status_reg, status_next;

    logic              in_accept;
    logic [CW-1:0]     n_now;
    logic              cmp_gt;
    logic [CW-1:0]     srch_s, srch_e;
    logic [CW:0]       sum_new;
    logic [CW-1:0]     mid_new;
    logic              more;
    logic [DIFF_W-1:0] dp, dk, dc;
    logic [RES_W-1:0]  q_s, r_sum;

    logic              tbl_wr_en;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [AW-1:0]     tbl_rd_addr;
    entry_t            tbl_rd_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (entries_in_use_reg < CNT_W'(2))
        begin
            n_now = CW'(2);
        end
        else if (32'(entries_in_use_reg) > 32'(TABLE_DEPTH))
        begin
            n_now = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_now = CW'(entries_in_use_reg);
        end
    end

    // one search step on the probe data that just came back
    assign cmp_gt  = tbl_rd_data.cdf > VAL_W'(key_reg);
    assign srch_s  = cmp_gt ? start_reg : mid_reg;
    assign srch_e  = cmp_gt ? mid_reg : end_reg;
    assign sum_new = {1'b0, srch_s} + {1'b0, srch_e};
    assign mid_new = CW'(sum_new >> 1);
    assign more    = (srch_e - srch_s) > CW'(1);

    assign dp = DIFF_W'(tbl_rd_data.point) - DIFF_W'(ps_reg);
    assign dk = DIFF_W'(key_reg) - DIFF_W'(cs_reg);
    assign dc = DIFF_W'(tbl_rd_data.cdf) - DIFF_W'(cs_reg);

    assign q_s   = neg_reg ? -RES_W'(div_rsp.quo) : RES_W'(div_rsp.quo);
    assign r_sum = RES_W'(ps_reg) + q_s;

    assign tbl_wr_en   = in_accept && (action == ACT_LOAD)
                         && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign tbl_wr_data = '{cdf: cdf_value, point: point_value};

    assign div_req = '{start: (state_reg == S_DIV_GO), num: prod_reg, den: dc_mag_reg};

    always_comb
    begin
        state_next          = state_reg;
        entries_in_use_next = entries_in_use_reg;
        out_valid_next      = out_valid_reg;
        n_next              = n_reg;
        start_next          = start_reg;
        end_next            = end_reg;
        mid_next            = mid_reg;
        key_next            = key_reg;
        cs_next             = cs_reg;
        ps_next             = ps_reg;
        dp_mag_next         = dp_mag_reg;
        dk_mag_next         = dk_mag_reg;
        dc_mag_next         = dc_mag_reg;
        neg_next            = neg_reg;
        prod_next           = prod_reg;
        res_sample_next     = res_sample_reg;
        res_status_next     = res_status_reg;
        sample_next         = sample_reg;
        status_next         = status_reg;
        tbl_rd_en           = 1'b0;
        tbl_rd_addr         = mid_new[AW-1:0];

        if (cfg_wr_en)
        begin
            entries_in_use_next = cfg_wr_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_QUERY))
                begin
                    // first probe goes out with the accept
                    n_next      = n_now;
                    start_next  = '0;
                    end_next    = n_now;
                    mid_next    = n_now >> 1;
                    key_next    = key;
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = mid_next[AW-1:0];
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                start_next = srch_s;
                end_next   = srch_e;
                tbl_rd_en  = 1'b1;
                if (more)
                begin
                    mid_next    = mid_new;
                    tbl_rd_addr = mid_new[AW-1:0];
                end
                else
                begin
                    tbl_rd_addr = srch_s[AW-1:0];
                    state_next  = S_RD_E;
                end
            end
            S_RD_E:
            begin
                cs_next     = tbl_rd_data.cdf;
                ps_next     = tbl_rd_data.point;
                tbl_rd_en   = (end_reg != n_reg);
                tbl_rd_addr = end_reg[AW-1:0];
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                dp_mag_next = mag(dp);
                dk_mag_next = mag(dk);
                dc_mag_next = mag(dc);
                neg_next    = dp[DIFF_W-1] ^ dk[DIFF_W-1] ^ dc[DIFF_W-1];
                if (end_reg == n_reg)
                begin
                    res_sample_next = ps_reg;   // start is the last entry here
                    res_status_next = ST_CLAMPED;
                    state_next      = S_FINISH;
                end
                else if (tbl_rd_data.cdf == cs_reg)
                begin
                    res_sample_next = ps_reg;
                    res_status_next = ST_FLAT;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = dp_mag_reg * dk_mag_reg;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_status_next = ST_NORMAL;
                    if (div_rsp.overflow)
                    begin
                        res_sample_next = neg_reg ? '0 : ONE_VAL;
                    end
                    else if (r_sum[RES_W-1])
                    begin
                        res_sample_next = '0;
                    end
                    else if (r_sum > RES_W'(ONE_VAL))
                    begin
                        res_sample_next = ONE_VAL;
                    end
                    else
                    begin
                        res_sample_next = r_sum[VAL_W-1:0];
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = res_sample_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            entries_in_use_reg <= ENTRIES_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            entries_in_use_reg <= entries_in_use_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        cs_reg         <= cs_next;
        ps_reg         <= ps_next;
        dp_mag_reg     <= dp_mag_next;
        dk_mag_reg     <= dk_mag_next;
        dc_mag_reg     <= dc_mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        res_sample_reg <= res_sample_next;
        res_status_reg <= res_status_next;
        sample_reg     <= sample_next;
        status_reg     <= status_next;
    end

    icdf_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    icdf_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign status    = status_reg;

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (start_reg < end_reg))
        else $error("search window empty");

    a_clamp_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIFF) && (end_reg == n_reg)) |-> (start_reg + CW'(1) == n_reg))
        else $error("clamp without start on last entry");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside finish");

endmodule

`default_nettype wire

>>> tb/tb_inverse_cdf_table_sampler_core.sv
// Self-checking testbench for the inverse-CDF table sampler core: table loads, searches, interpolation.
module tb_inverse_cdf_table_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import icdf_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [VAL_W-1:0] sample;
        status_t          status;
    } sample_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                action      = ACT_LOAD;
    logic [IDX_W-1:0]    entry_index = '0;
    logic [VAL_W-1:0]    cdf_value   = '0;
    logic [VAL_W-1:0]    point_value = '0;
    logic [KEY_W-1:0]    key         = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [VAL_W-1:0]    sample;
    logic [STATUS_W-1:0] status;

    // shadow copy of the tables and the entry count
    logic [VAL_W-1:0] cdf_mirror   [DEPTH];
    logic [VAL_W-1:0] point_mirror [DEPTH];
    logic [CNT_W-1:0] entries_mirror = ENTRIES_RST;

    sample_t     pending_samples[$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    bit          steady     = 1'b0;   // no idling on either side

    inverse_cdf_table_sampler_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .entry_index(entry_index),
        .cdf_value  (cdf_value),
        .point_value(point_value),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("inverse_cdf_table_sampler_core verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 8);

    function automatic int unsigned active_entries();
        if (entries_mirror < 2)
            return 2;
        if (entries_mirror > DEPTH)
            return DEPTH;
        return entries_mirror;
    endfunction

    function automatic sample_t interp_sample(input logic [KEY_W-1:0] k);
        sample_t     res;
        int unsigned n, lo, hi, mid;
        longint      ps, dp, dk, dc, r;
        n  = active_entries();
        lo = 0;
        hi = n;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (cdf_mirror[mid] > k)
                hi = mid;
            else
                lo = mid;
        end
        if (hi >= n)
        begin
            res.sample = point_mirror[n - 1];
            res.status = ST_CLAMPED;
        end
        else if (cdf_mirror[hi] == cdf_mirror[lo])
        begin
            res.sample = point_mirror[lo];
            res.status = ST_FLAT;
        end
        else
        begin
            ps = longint'(point_mirror[lo]);
            dp = longint'(point_mirror[hi]) - ps;
            dk = longint'(k) - longint'(cdf_mirror[lo]);
            dc = longint'(cdf_mirror[hi]) - longint'(cdf_mirror[lo]);
            r  = ps + (dp * dk) / dc;   // SV division truncates toward zero
            if (r < 0)
                r = 0;
            if (r > longint'(ONE_VAL))
                r = longint'(ONE_VAL);
            res.sample = VAL_W'(r);
            res.status = ST_NORMAL;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin : check_results
        sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("unexpected word, sample", -1, int'(sample));
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want.sample)
                    report_mismatch("sample", int'(want.sample), int'(sample));
                if (status !== want.status)
                    report_mismatch("status", int'(want.status), int'(status));
            end
        end
    end

    // Drives one word from the falling edge; returns at the accepting rising edge.
    task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] cval, input logic [VAL_W-1:0] pval,
                             input logic [KEY_W-1:0] k);
        @(negedge clk);
        if (!steady && $urandom_range(2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        cdf_value   <= cval;
        point_value <= pval;
        key         <= k;
        do
            @(posedge clk);
        while (!in_ready);
        if (act == ACT_LOAD)
        begin
            cdf_mirror[idx]   = cval;
            point_mirror[idx] = pval;
        end
        else
            pending_samples.push_back(interp_sample(k));
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] cval,
                              input logic [VAL_W-1:0] pval);
        send_word(ACT_LOAD, idx, cval, pval, KEY_W'($urandom));
    endtask

    task automatic query_key(input logic [KEY_W-1:0] k);
        send_word(ACT_QUERY, IDX_W'($urandom), VAL_W'($urandom_range(ONE_VAL)),
                  VAL_W'($urandom_range(ONE_VAL)), k);
    endtask

    // Drop valid, wait for every result, then let a trailing load finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_entries(input logic [CNT_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        entries_mirror = v;
    endtask

    // Monotonic cdf with some flat steps; points wander or jump.
    task automatic build_table(input int unsigned n);
        int c, p, step_max;
        c        = $urandom_range(3000);
        p        = $urandom_range(ONE_VAL);
        step_max = $urandom_range(196608, 65536) / n;
        for (int i = 0; i < n; i++)
        begin
            load_entry(IDX_W'(i), VAL_W'(c), VAL_W'(p));
            if ($urandom_range(7) != 0)
                c += $urandom_range(step_max, 1);
            if (c > int'(ONE_VAL))
                c = ONE_VAL;
            if ($urandom_range(3) == 0)
                p = $urandom_range(ONE_VAL);
            else
                p += int'($urandom_range(4000)) - 2000;
            p = (p < 0) ? 0 : (p > int'(ONE_VAL)) ? int'(ONE_VAL) : p;
        end
    endtask

    task automatic test_flat_and_clamp();
        set_entries(4);
        load_entry(0, 30000, 65536);
        load_entry(1, 30000, 0);
        load_entry(2, 40000, 20000);
        load_entry(3, 65536, 65535);
        query_key(0);        // below a flat first pair
        query_key(35000);
        query_key(30000);
        query_key(65535);    // last entry is one, so no clamp
        set_entries(3);
        query_key(65535);
        query_key(40000);
    endtask

    task automatic test_extrapolation();
        set_entries(2);
        load_entry(0, 10000, 0);
        load_entry(1, 50000, 65536);
        query_key(0);        // extrapolates below zero
        query_key(10000);
        query_key(49999);
        query_key(50000);
        load_entry(0, 10000, 65536);
        load_entry(1, 50000, 0);
        query_key(0);        // extrapolates above one
        query_key(10001);    // negative slope, truncation toward zero
    endtask

    task automatic test_entry_count_limits();
        set_entries(1);
        query_key(30000);
        set_entries(0);
        query_key(65535);
    endtask

    task automatic run_random_phase(input logic [CNT_W-1:0] setting, input bit rebuild,
                                    input int unsigned queries);
        int unsigned n, i;
        int          v;
        set_entries(setting);
        n = active_entries();
        if (rebuild)
            build_table(n);
        for (int j = 0; j < queries; j++)
        begin
            if ($urandom_range(99) < 7)
                load_entry(IDX_W'($urandom), VAL_W'($urandom_range(ONE_VAL)),
                           VAL_W'($urandom_range(ONE_VAL)));
            i = $urandom_range(n - 1);
            case ($urandom_range(3))
                0:       v = $urandom_range(65535);
                1:       v = int'(cdf_mirror[i]) + int'($urandom_range(2)) - 1;
                default: v = $urandom_range(cdf_mirror[n - 1], cdf_mirror[0]);
            endcase
            v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
            query_key(KEY_W'(v));
        end
    endtask

    task automatic test_random_tables();
        logic [CNT_W-1:0] settings [13] = '{128, 255, 2, 0, 1, 3, 7, 16, 33, 64, 100, 127, 128};
        // first pass fills every entry, so later counts never reach unwritten ones
        for (int k = 0; k < 13; k++)
        begin
            steady = (k == 1);
            run_random_phase(settings[k], (k == 0) || (k >= 2 && k <= 9), 70);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_flat_and_clamp();
        test_extrapolation();
        test_entry_count_limits();
        test_random_tables();
        settle();
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("inverse_cdf_table_sampler_core verification clean");
        else
            $display("inverse_cdf_table_sampler_core verification failed");
        $finish;
    end

endmodule
